[hdl/pulse_beat_detector_core_assert.svh]
// Assertion macros for the pulse beat detector checker.
`ifndef PULSE_BEAT_DETECTOR_CORE_ASSERT_SVH
`define PULSE_BEAT_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication, switched off during reset.
`define PBD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pulse beat detector check failed");

// Next-cycle implication, switched off during reset.
`define PBD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pulse beat detector check failed");

`endif

[hdl/pbd_pkg.sv]
// Types, constants, coefficient table and microcode ROM of the pulse beat detector.
`timescale 1ns / 1ps
package pbd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int RING_DEPTH  = 32;
   localparam int RING_AW     = $clog2(RING_DEPTH);
   localparam int HALF_TAPS   = 11;
   localparam int TAP_SPAN    = 2 * HALF_TAPS;
   localparam int DATA_BITS   = 18;
   localparam int COEF_BITS   = 13;
   localparam int K_BITS      = 4;
   localparam int STEP_BITS   = 5;

   localparam logic [DATA_BITS-1:0] SPAN_LOW_RESET  = 18'd1000;
   localparam logic [DATA_BITS-1:0] SPAN_HIGH_RESET = 18'd3000;
   localparam logic signed [DATA_BITS-1:0] CYCLE_MAX_RESET = 18'sd20;
   localparam logic signed [DATA_BITS-1:0] CYCLE_MIN_RESET = -18'sd20;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_SPAN_LOW  = 2'd0;
   localparam logic [1:0] CSR_SPAN_HIGH = 2'd1;

   // Jump conditions of the microcode.
   localparam logic [1:0] JC_NEXT     = 2'd0;
   localparam logic [1:0] JC_ALWAYS   = 2'd1;
   localparam logic [1:0] JC_NO_REQ   = 2'd2;
   localparam logic [1:0] JC_OUT_BUSY = 2'd3;

   typedef struct packed {
      logic [1:0]           cond;
      logic [STEP_BITS-1:0] target;
      logic                 last;
      logic                 take;
      logic                 ring_wr;
      logic                 acc_clr;
      logic                 rd_en;
      logic [K_BITS-1:0]    rd_k;
      logic                 mul_en;
      logic                 acc_en;
      logic                 finish;
   } ucode_type;

   typedef struct packed {
      logic req_valid;
      logic out_busy;
   } seq_status_type;

   typedef struct packed {
      logic              open;
      logic              take;
      logic              ring_wr;
      logic              acc_clr;
      logic              rd_en;
      logic [K_BITS-1:0] rd_k;
      logic              mul_en;
      logic              acc_en;
      logic              finish;
   } ctl_type;

   function automatic logic [COEF_BITS-1:0] fir_coef(input logic [K_BITS-1:0] k);
      logic [COEF_BITS-1:0] c;
      unique case (k)
         4'd0:    c = 13'd172;
         4'd1:    c = 13'd321;
         4'd2:    c = 13'd579;
         4'd3:    c = 13'd927;
         4'd4:    c = 13'd1360;
         4'd5:    c = 13'd1858;
         4'd6:    c = 13'd2390;
         4'd7:    c = 13'd2916;
         4'd8:    c = 13'd3391;
         4'd9:    c = 13'd3768;
         4'd10:   c = 13'd4012;
         4'd11:   c = 13'd4096;
         default: c = 13'd0;
      endcase
      return c;
   endfunction

   // Program: take a request, write the ring, twelve pipelined multiply-accumulate
   // steps (read, multiply, accumulate), then finish once the output register is free.
   // Fields: cond, target, last, take, ring_wr, acc_clr, rd_en, rd_k, mul_en, acc_en, finish
   function automatic ucode_type ucode_rom(input logic [STEP_BITS-1:0] step);
      ucode_type w;
      unique case (step)
         5'd0:  w = '{JC_NO_REQ, 5'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0,
                      1'b0, 1'b0, 1'b0};
         5'd1:  w = '{JC_NEXT, 5'd0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 4'd0,
                      1'b0, 1'b0, 1'b0};
         5'd2:  w = '{JC_NEXT, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0,
                      1'b0, 1'b0, 1'b0};
         5'd3:  w = '{JC_NEXT, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd1,
                      1'b1, 1'b0, 1'b0};
         5'd4:  w = '{JC_NEXT, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd2,
                      1'b1, 1'b1, 1'b0};
         5'd5:  w = '{JC_NEXT, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd3,
                      1'b1, 1'b1, 1'b0};
         5'd6:  w = '{JC_NEXT, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd4,
                      1'b1, 1'b1, 1'b0};
         5'd7:  w = '{JC_NEXT, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd5,
                      1'b1, 1'b1, 1'b0};
         5'd8:  w = '{JC_NEXT, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd6,
                      1'b1, 1'b1, 1'b0};
         5'd9:  w = '{JC_NEXT, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd7,
                      1'b1, 1'b1, 1'b0};
         5'd10: w = '{JC_NEXT, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd8,
                      1'b1, 1'b1, 1'b0};
         5'd11: w = '{JC_NEXT, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd9,
                      1'b1, 1'b1, 1'b0};
         5'd12: w = '{JC_NEXT, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd10,
                      1'b1, 1'b1, 1'b0};
         5'd13: w = '{JC_NEXT, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd11,
                      1'b1, 1'b1, 1'b0};
         5'd14: w = '{JC_NEXT, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,
                      1'b1, 1'b1, 1'b0};
         5'd15: w = '{JC_NEXT, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,
                      1'b0, 1'b1, 1'b0};
         5'd16: w = '{JC_OUT_BUSY, 5'd16, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,
                      1'b0, 1'b0, 1'b1};
         default: w = '{JC_ALWAYS, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,
                        1'b0, 1'b0, 1'b0};
      endcase
      return w;
   endfunction

endpackage

[hdl/pbd_sequencer.sv]
// Microcode sequencer: step counter, program ROM and conditional jumps.
`timescale 1ns / 1ps
module pbd_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  pbd_pkg::seq_status_type status,
   output pbd_pkg::ctl_type        ctl
);

   logic [pbd_pkg::STEP_BITS-1:0] step_ff;
   logic [pbd_pkg::STEP_BITS-1:0] step_in;
   pbd_pkg::ucode_type            word;
   logic                          jump;

   assign word = pbd_pkg::ucode_rom(step_ff);

   always_comb begin
      unique case (word.cond)
         pbd_pkg::JC_NEXT:     jump = 1'b0;
         pbd_pkg::JC_ALWAYS:   jump = 1'b1;
         pbd_pkg::JC_NO_REQ:   jump = !status.req_valid;
         pbd_pkg::JC_OUT_BUSY: jump = status.out_busy;
         default:              jump = 1'b0;
      endcase
      if (jump) begin
         step_in = word.target;
      end else if (word.last) begin
         step_in = '0;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      ctl.open    = word.take;
      ctl.take    = word.take && status.req_valid;
      ctl.ring_wr = word.ring_wr;
      ctl.acc_clr = word.acc_clr;
      ctl.rd_en   = word.rd_en;
      ctl.rd_k    = word.rd_k;
      ctl.mul_en  = word.mul_en;
      ctl.acc_en  = word.acc_en;
      ctl.finish  = word.finish && !status.out_busy;
   end

endmodule

[hdl/pulse_beat_detector_core.sv]
// Pulse beat detector top level: baseline tracker, 23-tap FIR and beat decision.
// Requests are worked on one at a time: the next is taken only after the microcode program
// has run its twelve multiply-accumulate steps over the two-read-port tap ring, plus
// their pipeline fill, and its finishing step.
// Synchronous reset clears control state and ring valid bits; no clearing pass is needed.
`timescale 1ns / 1ps
module pulse_beat_detector_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [pbd_pkg::SAMPLE_BITS-1:0]      req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_beat,
   output logic signed [pbd_pkg::DATA_BITS-1:0] rsp_filtered,
   output logic [pbd_pkg::SAMPLE_BITS-1:0]      rsp_baseline,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [1:0]                           csr_index,
   input  logic [pbd_pkg::DATA_BITS-1:0]        csr_wdata
);

   // The sequencer walks a fixed program of seventeen steps. Step zero waits for a
   // request and updates the baseline accumulator as the sample is taken. Step one
   // writes the AC sample into the ring. Steps two to thirteen read a tap pair each,
   // the multiply works on the registered pair and the accumulate on the product,
   // and the last step settles the crossing logic and loads the output register.

   localparam int PAIR_BITS = pbd_pkg::DATA_BITS + 1;
   localparam int PROD_BITS = PAIR_BITS + pbd_pkg::COEF_BITS + 1;
   localparam int ACC_BITS  = PROD_BITS + 2;
   localparam int DC_BITS   = 32;

   pbd_pkg::ctl_type        ctl;
   pbd_pkg::seq_status_type status;

   // Configuration registers.
   logic [pbd_pkg::DATA_BITS-1:0] span_low_ff;
   logic [pbd_pkg::DATA_BITS-1:0] span_high_ff;

   // Baseline tracker.
   logic [pbd_pkg::SAMPLE_BITS-1:0] sample_ff;
   logic [DC_BITS-1:0]              dc_ff;
   logic [DC_BITS-1:0]              dc_in;
   logic signed [DC_BITS:0]         dc_diff;
   logic signed [DC_BITS:0]         dc_step;
   logic [pbd_pkg::SAMPLE_BITS-1:0] baseline;
   logic signed [pbd_pkg::DATA_BITS-1:0] ac_value;

   // Tap ring and its read side.
   logic [pbd_pkg::DATA_BITS-1:0] ring_mem [pbd_pkg::RING_DEPTH];
   logic [pbd_pkg::RING_DEPTH-1:0] ring_vld_ff;
   logic [pbd_pkg::RING_AW-1:0]   ptr_ff;
   logic [pbd_pkg::RING_AW-1:0]   addr_a;
   logic [pbd_pkg::RING_AW-1:0]   addr_b;
   logic [pbd_pkg::DATA_BITS-1:0] rd_a_ff;
   logic [pbd_pkg::DATA_BITS-1:0] rd_b_ff;
   logic                          rd_va_ff;
   logic                          rd_vb_ff;
   logic [pbd_pkg::K_BITS-1:0]    k_ff;

   // Multiply-accumulate.
   logic signed [pbd_pkg::DATA_BITS-1:0] op_a;
   logic signed [pbd_pkg::DATA_BITS-1:0] op_b;
   logic signed [PAIR_BITS-1:0]          pair_sum;
   logic signed [PROD_BITS-1:0]          prod_in;
   logic signed [PROD_BITS-1:0]          prod_ff;
   logic signed [ACC_BITS-1:0]           acc_ff;
   logic signed [pbd_pkg::DATA_BITS-1:0] cur;

   // Crossing and beat tracking.
   logic signed [pbd_pkg::DATA_BITS-1:0] last_ff;
   logic signed [pbd_pkg::DATA_BITS-1:0] rmax_ff, rmax_in;
   logic signed [pbd_pkg::DATA_BITS-1:0] rmin_ff, rmin_in;
   logic signed [pbd_pkg::DATA_BITS-1:0] cmax_ff, cmax_in;
   logic signed [pbd_pkg::DATA_BITS-1:0] cmin_ff, cmin_in;
   logic                                 rising_ff, rising_in;
   logic                                 falling_ff, falling_in;
   logic                                 cross_up;
   logic                                 cross_down;
   logic signed [PAIR_BITS-1:0]          span;
   logic                                 beat_in;

   // Output register.
   logic                                 rsp_valid_ff;
   logic                                 rsp_beat_ff;
   logic signed [pbd_pkg::DATA_BITS-1:0] rsp_filtered_ff;
   logic [pbd_pkg::SAMPLE_BITS-1:0]      rsp_baseline_ff;

   // ---------------------------------------------------------------------------------
   // Sequencer. A request is taken only at the first step; the finishing step holds
   // while an earlier result still sits stalled in the output register.
   // ---------------------------------------------------------------------------------
   assign status.req_valid = req_valid;
   assign status.out_busy  = rsp_valid_ff && rsp_stall;

   pbd_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   assign req_stall = !ctl.open;

   // ---------------------------------------------------------------------------------
   // Configuration port. Writes are always accepted; an index beyond the two
   // registers is simply ignored.
   // ---------------------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         span_low_ff  <= pbd_pkg::SPAN_LOW_RESET;
         span_high_ff <= pbd_pkg::SPAN_HIGH_RESET;
      end else if (csr_valid) begin
         if (csr_index == pbd_pkg::CSR_SPAN_LOW) begin
            span_low_ff <= csr_wdata;
         end
         if (csr_index == pbd_pkg::CSR_SPAN_HIGH) begin
            span_high_ff <= csr_wdata;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Baseline tracker. The accumulator holds the baseline in Q15 and moves a
   // sixteenth of the way towards the new sample, rounding towards minus infinity
   // through the arithmetic shift. It never leaves the range of a Q15 sample.
   // ---------------------------------------------------------------------------------
   assign dc_diff = $signed({2'b00, req_sample, 15'd0}) - $signed({1'b0, dc_ff});
   assign dc_step = dc_diff >>> 4;
   assign dc_in   = dc_ff + dc_step[DC_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_ff <= '0;
      end else if (ctl.take) begin
         dc_ff <= dc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.take) begin
         sample_ff <= req_sample;
      end
   end

   assign baseline = dc_ff[15 +: pbd_pkg::SAMPLE_BITS];
   assign ac_value = $signed({2'b00, sample_ff}) - $signed({2'b00, baseline});

   // ---------------------------------------------------------------------------------
   // Tap ring: one write port and two registered read ports. An entry that has not
   // been written since reset carries a clear valid bit and reads as zero.
   // ---------------------------------------------------------------------------------
   assign addr_a = ptr_ff - pbd_pkg::RING_AW'(ctl.rd_k);
   assign addr_b = ptr_ff - (pbd_pkg::RING_AW'(pbd_pkg::TAP_SPAN)
                             - pbd_pkg::RING_AW'(ctl.rd_k));

   always_ff @(posedge clock) begin
      if (ctl.ring_wr) begin
         ring_mem[ptr_ff] <= ac_value;
      end
      if (ctl.rd_en) begin
         rd_a_ff  <= ring_mem[addr_a];
         rd_b_ff  <= ring_mem[addr_b];
         rd_va_ff <= ring_vld_ff[addr_a];
         rd_vb_ff <= ring_vld_ff[addr_b];
         k_ff     <= ctl.rd_k;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff <= '0;
         ptr_ff      <= '0;
      end else begin
         if (ctl.ring_wr) begin
            ring_vld_ff[ptr_ff] <= 1'b1;
         end
         if (ctl.finish) begin
            ptr_ff <= ptr_ff + 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Multiply-accumulate. Each step folds a symmetric tap pair before the multiply;
   // the centre tap has no partner. The accumulator is wide enough never to wrap.
   // ---------------------------------------------------------------------------------
   assign op_a = rd_va_ff ? $signed(rd_a_ff) : '0;
   assign op_b = (rd_vb_ff && (k_ff != pbd_pkg::K_BITS'(pbd_pkg::HALF_TAPS)))
                 ? $signed(rd_b_ff) : '0;
   assign pair_sum = PAIR_BITS'(op_a) + PAIR_BITS'(op_b);
   assign prod_in  = PROD_BITS'(pair_sum)
                     * PROD_BITS'($signed({1'b0, pbd_pkg::fir_coef(k_ff)}));

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.acc_clr) begin
         acc_ff <= '0;
      end else if (ctl.acc_en) begin
         acc_ff <= acc_ff + ACC_BITS'(prod_ff);
      end
   end

   // The floored shift by fifteen always fits the filtered width.
   assign cur = acc_ff[15 +: pbd_pkg::DATA_BITS];

   // ---------------------------------------------------------------------------------
   // Zero crossings. A rising crossing latches the tracked extremes of the cycle just
   // ended and judges the beat; a falling crossing restarts the minimum. The phase
   // flags then decide whether the new value extends the tracked extreme.
   // ---------------------------------------------------------------------------------
   assign cross_up   = last_ff[pbd_pkg::DATA_BITS-1] && !cur[pbd_pkg::DATA_BITS-1];
   assign cross_down = (last_ff > 0) && (cur <= 0);

   always_comb begin
      rising_in  = rising_ff;
      falling_in = falling_ff;
      rmax_in    = rmax_ff;
      rmin_in    = rmin_ff;
      cmax_in    = cmax_ff;
      cmin_in    = cmin_ff;
      if (cross_up) begin
         cmax_in    = rmax_ff;
         cmin_in    = rmin_ff;
         rising_in  = 1'b1;
         falling_in = 1'b0;
         rmax_in    = '0;
      end
      if (cross_down) begin
         rising_in  = 1'b0;
         falling_in = 1'b1;
         rmin_in    = '0;
      end
      if (rising_in && (cur > last_ff)) begin
         rmax_in = cur;
      end
      if (falling_in && (cur < last_ff)) begin
         rmin_in = cur;
      end
      span    = PAIR_BITS'(cmax_in) - PAIR_BITS'(cmin_in);
      beat_in = cross_up
                && ($signed({span[PAIR_BITS-1], span}) > $signed({2'b00, span_low_ff}))
                && ($signed({span[PAIR_BITS-1], span}) < $signed({2'b00, span_high_ff}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff    <= '0;
         rmax_ff    <= '0;
         rmin_ff    <= '0;
         cmax_ff    <= pbd_pkg::CYCLE_MAX_RESET;
         cmin_ff    <= pbd_pkg::CYCLE_MIN_RESET;
         rising_ff  <= 1'b0;
         falling_ff <= 1'b0;
      end else if (ctl.finish) begin
         last_ff    <= cur;
         rmax_ff    <= rmax_in;
         rmin_ff    <= rmin_in;
         cmax_ff    <= cmax_in;
         cmin_ff    <= cmin_in;
         rising_ff  <= rising_in;
         falling_ff <= falling_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Output register. It parts the result side from the datapath, so a new request
   // can be taken and worked on while the previous result waits to be collected.
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         rsp_beat_ff     <= beat_in;
         rsp_filtered_ff <= cur;
         rsp_baseline_ff <= baseline;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_beat     = rsp_beat_ff;
   assign rsp_filtered = rsp_filtered_ff;
   assign rsp_baseline = rsp_baseline_ff;

endmodule

[hdl/pbd_checker.sv]
// Port-level checker for the pulse beat detector, bound to the top level.
`timescale 1ns / 1ps
`include "pulse_beat_detector_core_assert.svh"
module pbd_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic                                 rsp_beat,
   input logic signed [pbd_pkg::DATA_BITS-1:0] rsp_filtered,
   input logic [pbd_pkg::SAMPLE_BITS-1:0]      rsp_baseline
);

   // A stalled result keeps its place and its contents.
   `PBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_beat) && $stable(rsp_filtered) && $stable(rsp_baseline))

   // Work on one request at a time: a taken request closes the input.
   `PBD_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && !req_stall, req_stall)

   // A new result is only produced from the finishing step, with the input closed.
   `PBD_ASSERT_IMPL(a_result_source, clock, reset, $rose(rsp_valid), $past(req_stall))

   // A beat comes only on a rising crossing, so its filtered value is never negative.
   `PBD_ASSERT_IMPL(a_beat_sign, clock, reset, rsp_valid && rsp_beat, !rsp_filtered[pbd_pkg::DATA_BITS-1])

endmodule

bind pulse_beat_detector_core pbd_checker u_pbd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_beat     (rsp_beat),
   .rsp_filtered (rsp_filtered),
   .rsp_baseline (rsp_baseline)
);
